[rtl/qvu_pkg.sv]
package qvu_pkg;

    // Default chain length
    localparam int unsigned NumStatesDef = 16;

    // Configuration register indexes
    localparam logic [7:0] CFG_ENABLE    = 8'd0;
    localparam logic [7:0] CFG_LEARN     = 8'd1;
    localparam logic [7:0] CFG_DISCOUNT  = 8'd2;
    localparam logic [7:0] CFG_THRESHOLD = 8'd3;

    // Configuration reset values
    localparam logic [14:0] LearnRateRst = 15'd3277;
    localparam logic [14:0] DiscountRst  = 15'd24576;
    localparam logic [15:0] ThresholdRst = 16'd32767;

    // Action codes
    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_STAY = 2'd1;
    localparam logic [1:0] ACT_UP   = 2'd2;

    // Input transaction
    typedef struct packed {
        logic signed [15:0] reward;
        logic [15:0]        random_word;
        logic [1:0]         random_action;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [1:0]         chosen_action;
        logic               explored;
        logic signed [31:0] future_max;
        logic signed [31:0] updated_value;
        logic [7:0]         next_state;
    } t_out;

    // Value table read address select
    typedef enum logic [1:0] {
        RD_DN,
        RD_CUR,
        RD_UP
    } t_rd_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        logic    cap_dn;
        logic    cap_cur;
        logic    cap_up;
        logic    do_max;
        logic    do_sum;
        logic    do_mlo;
        logic    do_mhi;
        logic    do_wb;
    } t_cmd;

endpackage

[rtl/qvu_ctrl.sv]
module qvu_ctrl import qvu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_enable,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DN,
        S_RD_CUR,
        S_RD_UP,
        S_MAX,
        S_SUM,
        S_MLO,
        S_MHI,
        S_WB
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_wb_go;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    // write back only once the output register is free or draining
    assign w_wb_go     = (r_state == S_WB) && (!r_out_valid || !i_out_stall);

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wb_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // disabled transactions are taken and dropped
                    if (w_accept && i_enable) begin
                        r_state <= S_RD_DN;
                    end
                end
                S_RD_DN:  r_state <= S_RD_CUR;
                S_RD_CUR: r_state <= S_RD_UP;
                S_RD_UP:  r_state <= S_MAX;
                S_MAX:    r_state <= S_SUM;
                S_SUM:    r_state <= S_MLO;
                S_MLO:    r_state <= S_MHI;
                S_MHI:    r_state <= S_WB;
                S_WB: begin
                    if (w_wb_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_DN;
        o_cmd.load    = w_accept && i_enable;
        o_cmd.do_wb   = w_wb_go;
        case (r_state)
            S_IDLE:   o_cmd.rd_sel = RD_DN;
            S_RD_DN: begin
                o_cmd.cap_dn = 1'b1;
                o_cmd.rd_sel = RD_CUR;
            end
            S_RD_CUR: begin
                o_cmd.cap_cur = 1'b1;
                o_cmd.rd_sel  = RD_UP;
            end
            S_RD_UP:  o_cmd.cap_up = 1'b1;
            S_MAX:    o_cmd.do_max = 1'b1;
            S_SUM:    o_cmd.do_sum = 1'b1;
            S_MLO:    o_cmd.do_mlo = 1'b1;
            S_MHI:    o_cmd.do_mhi = 1'b1;
            default:  o_cmd.rd_sel = RD_DN;
        endcase
    end

endmodule

[rtl/qvu_dp.sv]
module qvu_dp import qvu_pkg::*; #(
    parameter int unsigned NUM_STATES = NumStatesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_in_data,
    input  logic [14:0] i_learn_rate,
    input  logic [14:0] i_discount,
    input  logic [15:0] i_threshold,
    output t_out        o_out_data
);

    localparam int unsigned SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam logic [SW-1:0] LastState = SW'(NUM_STATES - 1);

    // Value table with per-entry valid bits (invalid entries read as zero)
    logic signed [31:0] r_mem [NUM_STATES];
    logic [NUM_STATES-1:0] r_vld;
    logic signed [31:0] r_rd_data;
    logic               r_rd_vld;
    logic signed [31:0] w_rd_value;
    logic [SW-1:0]      w_rd_addr;

    // Present state and neighbor indexes
    logic [SW-1:0] r_present;
    logic [SW-1:0] w_idx_dn;
    logic [SW-1:0] w_idx_up;
    logic          w_boundary;

    // Latched transaction
    logic signed [15:0] r_reward;
    logic               r_explore;
    logic [1:0]         r_ract;

    // Datapath registers
    logic signed [31:0] r_v_dn;
    logic signed [31:0] r_v_cur;
    logic signed [31:0] r_v_up;
    logic signed [31:0] r_best;
    logic [1:0]         r_act;
    logic signed [48:0] r_sum;
    logic [38:0]        r_plo;
    logic signed [63:0] r_prod;
    t_out               r_out;

    // Combinational next values
    logic signed [31:0] n_best;
    logic [1:0]         n_greedy;
    logic [1:0]         n_act;
    logic signed [47:0] n_gb;
    logic signed [48:0] n_sum;
    logic signed [39:0] n_phi;
    logic [63:0]        n_phi_sh;
    logic signed [63:0] n_prod;
    logic signed [33:0] n_delta;
    logic signed [34:0] n_nv;
    logic signed [31:0] n_sat;
    logic [SW-1:0]      n_next;

    assign w_idx_dn   = (r_present == '0) ? r_present : r_present - SW'(1);
    assign w_idx_up   = (r_present == LastState) ? r_present : r_present + SW'(1);
    assign w_boundary = (r_present == '0) || (r_present == LastState);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_DN:   w_rd_addr = w_idx_dn;
            RD_CUR:  w_rd_addr = r_present;
            RD_UP:   w_rd_addr = w_idx_up;
            default: w_rd_addr = r_present;
        endcase
    end

    assign w_rd_value = r_rd_vld ? r_rd_data : 32'sd0;

    // Table read and write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (i_cmd.do_wb) begin
            r_mem[r_present] <= n_sat;
        end
    end

    // Valid bits and registered read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[w_rd_addr];
            if (i_cmd.do_wb) begin
                r_vld[r_present] <= 1'b1;
            end
        end
    end

    // Max over neighbors, first maximum wins; then the action pick
    always_comb begin
        n_best   = r_v_dn;
        n_greedy = ACT_DOWN;
        if (r_v_cur > n_best) begin
            n_best   = r_v_cur;
            n_greedy = ACT_STAY;
        end
        if (r_v_up > n_best) begin
            n_best   = r_v_up;
            n_greedy = ACT_UP;
        end
        if (r_explore) begin
            n_act = (r_ract > ACT_UP) ? ACT_STAY : r_ract;
        end else if (w_boundary) begin
            n_act = ACT_DOWN;
        end else begin
            n_act = n_greedy;
        end
    end

    // reward*2^15 + gamma*best - cur*2^15
    assign n_gb  = $signed({1'b0, i_discount}) * r_best;
    assign n_sum = ($signed(49'(r_reward)) <<< 15) + 49'(n_gb)
                   - ($signed(49'(r_v_cur)) <<< 15);

    // High partial product of alpha*sum, joined with the low one
    assign n_phi    = $signed({1'b0, i_learn_rate}) * $signed(r_sum[48:24]);
    assign n_phi_sh = {n_phi, 24'b0};
    assign n_prod   = $signed(n_phi_sh) + $signed({25'b0, r_plo});

    // Divide by 2^30 toward zero, add, saturate
    always_comb begin
        n_delta = r_prod[63:30];
        if (r_prod[63] && (r_prod[29:0] != '0)) begin
            n_delta = n_delta + 34'sd1;
        end
        n_nv = 35'(r_v_cur) + 35'(n_delta);
        if (n_nv[34:31] == 4'b0000 || n_nv[34:31] == 4'b1111) begin
            n_sat = n_nv[31:0];
        end else if (n_nv[34]) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = 32'sh7FFF_FFFF;
        end
    end

    // Clamped move
    always_comb begin
        case (r_act)
            ACT_DOWN: n_next = w_idx_dn;
            ACT_UP:   n_next = w_idx_up;
            default:  n_next = r_present;
        endcase
    end

    // Present state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.do_wb) begin
            r_present <= n_next;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_reward  <= i_in_data.reward;
            r_explore <= (i_in_data.random_word > i_threshold);
            r_ract    <= i_in_data.random_action;
        end
        if (i_cmd.cap_dn) begin
            r_v_dn <= w_rd_value;
        end
        if (i_cmd.cap_cur) begin
            r_v_cur <= w_rd_value;
        end
        if (i_cmd.cap_up) begin
            r_v_up <= w_rd_value;
        end
        if (i_cmd.do_max) begin
            r_best <= n_best;
            r_act  <= n_act;
        end
        if (i_cmd.do_sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.do_mlo) begin
            r_plo <= {15'b0, r_sum[23:0]} * {24'b0, i_learn_rate};
        end
        if (i_cmd.do_mhi) begin
            r_prod <= n_prod;
        end
        if (i_cmd.do_wb) begin
            r_out.chosen_action <= r_act;
            r_out.explored      <= r_explore;
            r_out.future_max    <= r_best;
            r_out.updated_value <= n_sat;
            r_out.next_state    <= 8'(n_next);
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/q_value_update_epsilon_greedy.sv]
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall   t_in  i_in_data
// output    out        o_out_valid / i_out_stall t_out o_out_data
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One enabled transaction goes from acceptance to the next acceptance through
// three reads of the value table on its one read port, a compare, a sum with the gamma
// product, the alpha product in two halves and the write-back.
// A transaction taken while disabled is dropped in the cycle it arrives.
// Reset is synchronous; it clears the state and the table valid bits and loads the config reset values.
// A stalled output holds the write-back cycle until the output register frees.
module q_value_update_epsilon_greedy import qvu_pkg::*; #(
    parameter int unsigned NUM_STATES = NumStatesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_enable;
    logic [14:0] r_learn_rate;
    logic [14:0] r_discount;
    logic [15:0] r_threshold;
    t_cmd        w_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_learn_rate <= LearnRateRst;
            r_discount   <= DiscountRst;
            r_threshold  <= ThresholdRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_enable     <= i_cfg_data[0];
                CFG_LEARN:     r_learn_rate <= i_cfg_data[14:0];
                CFG_DISCOUNT:  r_discount   <= i_cfg_data[14:0];
                CFG_THRESHOLD: r_threshold  <= i_cfg_data;
                default:       r_enable     <= r_enable;
            endcase
        end
    end

    qvu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    qvu_dp #(
        .NUM_STATES (NUM_STATES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_data    (i_in_data),
        .i_learn_rate (r_learn_rate),
        .i_discount   (r_discount),
        .i_threshold  (r_threshold),
        .o_out_data   (o_out_data)
    );

endmodule
